/* rtl/wmu_pkg.sv */
// wmu_pkg: shared types and constants of the wheel momentum unloading unit
// used by wmu_ctrl, wmu_dp and the top level; no dependencies
`default_nettype none

package wmu_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned DivSteps = 32;

  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_FRAC  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_FRAC = 8'd3;

  localparam logic [31:0] GAIN_RST      = 32'd65536;
  localparam logic [17:0] THRESHOLD_RST = 18'd20000;
  localparam logic [15:0] LOW_FRAC_RST  = 16'd16384;
  localparam logic [15:0] HIGH_FRAC_RST = 16'd52429;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQ,
    OP_THR,
    OP_HI,
    OP_LO,
    OP_CP,
    OP_CN,
    OP_GLO,
    OP_GHI
  } op_e;

  typedef struct packed {
    logic       load;
    op_e        op;
    logic [1:0] axis;
    logic       decide;
    logic       div_init;
    logic       div_step;
    logic       store;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic usable;
  } status_t;

endpackage

`default_nettype wire

/* rtl/wmu_dp.sv */
// wmu_dp: datapath with config registers, shared multiplier, flags,
// cross product, restoring divider and result registers; uses wmu_pkg
`default_nettype none

module wmu_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wmu_pkg::cmd_t                 cmd_i,
  output wmu_pkg::status_t                   status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wmu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic signed [17:0]            field_x_i,
  input  wire logic signed [17:0]            field_y_i,
  input  wire logic signed [17:0]            field_z_i,
  input  wire logic signed [23:0]            wheel_mom_x_i,
  input  wire logic signed [23:0]            wheel_mom_y_i,
  input  wire logic signed [23:0]            wheel_mom_z_i,
  input  wire logic [22:0]                   mom_limit_x_i,
  input  wire logic [22:0]                   mom_limit_y_i,
  input  wire logic [22:0]                   mom_limit_z_i,
  output logic signed [31:0]                 dipole_x_o,
  output logic signed [31:0]                 dipole_y_o,
  output logic signed [31:0]                 dipole_z_o,
  output logic [2:0]                         unload_mask_o,
  output logic                               field_usable_o
);

  logic [31:0] gain_q;
  logic [17:0] thr_q;
  logic [15:0] lo_frac_q;
  logic [15:0] hi_frac_q;

  logic signed [17:0] b_q [3];
  logic signed [23:0] h_q [3];
  logic [22:0]        lim_q [3];
  logic [2:0]         flags_q;

  logic signed [57:0] prod_q;
  wmu_pkg::op_e       opd_q;
  logic [1:0]         axd_q;

  logic [35:0]        m_q;
  logic [35:0]        thr2_q;
  logic               usable_q;
  logic signed [42:0] c_q;
  logic [73:0]        acc_q;
  logic [35:0]        rem_q;
  logic [31:0]        qs_q;
  logic               ovf_q;
  logic               neg_q;
  logic signed [31:0] dip_q [3];

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [17:0] b_sel, b_n1, b_n2;
  logic signed [23:0] he_n1, he_n2, h_wb;
  logic [22:0]        lim_sel;
  logic [1:0]         ax_n1, ax_n2;
  logic [41:0]        cmag;
  logic [23:0]        habs;
  logic [39:0]        ah;
  logic [57:0]        num;
  logic [36:0]        trial;
  logic [36:0]        diff;
  logic               ge;
  logic signed [31:0] sat_val;

  function automatic logic [1:0] next_axis(input logic [1:0] a);
    case (a)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  always_comb begin
    ax_n1 = next_axis(cmd_i.axis);
    ax_n2 = next_axis(ax_n1);
    case (cmd_i.axis)
      2'd1:    begin b_sel = b_q[1]; lim_sel = lim_q[1]; end
      2'd2:    begin b_sel = b_q[2]; lim_sel = lim_q[2]; end
      default: begin b_sel = b_q[0]; lim_sel = lim_q[0]; end
    endcase
    case (ax_n1)
      2'd1:    begin b_n1 = b_q[1]; he_n1 = flags_q[1] ? h_q[1] : '0; end
      2'd2:    begin b_n1 = b_q[2]; he_n1 = flags_q[2] ? h_q[2] : '0; end
      default: begin b_n1 = b_q[0]; he_n1 = flags_q[0] ? h_q[0] : '0; end
    endcase
    case (ax_n2)
      2'd1:    begin b_n2 = b_q[1]; he_n2 = flags_q[1] ? h_q[1] : '0; end
      2'd2:    begin b_n2 = b_q[2]; he_n2 = flags_q[2] ? h_q[2] : '0; end
      default: begin b_n2 = b_q[0]; he_n2 = flags_q[0] ? h_q[0] : '0; end
    endcase
    cmag = c_q[42] ? 42'(-c_q) : c_q[41:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      wmu_pkg::OP_SQ:  begin mul_a = 33'(b_sel); mul_b = 25'(b_sel); end
      wmu_pkg::OP_THR: begin mul_a = {15'b0, thr_q}; mul_b = {7'b0, thr_q}; end
      wmu_pkg::OP_HI:  begin mul_a = {17'b0, hi_frac_q}; mul_b = {2'b0, lim_sel}; end
      wmu_pkg::OP_LO:  begin mul_a = {17'b0, lo_frac_q}; mul_b = {2'b0, lim_sel}; end
      wmu_pkg::OP_CP:  begin mul_a = 33'(he_n1); mul_b = 25'(b_n2); end
      wmu_pkg::OP_CN:  begin mul_a = 33'(he_n2); mul_b = 25'(b_n1); end
      wmu_pkg::OP_GLO: begin mul_a = {1'b0, gain_q}; mul_b = {4'b0, cmag[20:0]}; end
      wmu_pkg::OP_GHI: begin mul_a = {1'b0, gain_q}; mul_b = {4'b0, cmag[41:21]}; end
      default:         begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    case (axd_q)
      2'd1:    h_wb = h_q[1];
      2'd2:    h_wb = h_q[2];
      default: h_wb = h_q[0];
    endcase
    habs  = h_wb[23] ? 24'(-h_wb) : h_wb;
    ah    = {habs, 16'h0};
    num   = acc_q[73:16];
    trial = {rem_q, qs_q[31]};
    diff  = trial - {1'b0, m_q};
    ge    = trial >= {1'b0, m_q};
    if (neg_q) begin
      sat_val = (ovf_q || qs_q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(qs_q);
    end else begin
      sat_val = (ovf_q || qs_q[31]) ? 32'sh7fff_ffff : $signed(qs_q);
    end
  end

  assign status_o.usable = m_q > thr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= wmu_pkg::GAIN_RST;
      thr_q     <= wmu_pkg::THRESHOLD_RST;
      lo_frac_q <= wmu_pkg::LOW_FRAC_RST;
      hi_frac_q <= wmu_pkg::HIGH_FRAC_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wmu_pkg::CFG_GAIN:      gain_q    <= cfg_data_i;
        wmu_pkg::CFG_THRESHOLD: thr_q     <= cfg_data_i[17:0];
        wmu_pkg::CFG_LOW_FRAC:  lo_frac_q <= cfg_data_i[15:0];
        wmu_pkg::CFG_HIGH_FRAC: hi_frac_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      opd_q   <= wmu_pkg::OP_NONE;
    end else begin
      opd_q <= cmd_i.op;
      if (opd_q == wmu_pkg::OP_HI && ah > prod_q[39:0]) begin
        flags_q[axd_q] <= 1'b1;
      end
      if (opd_q == wmu_pkg::OP_LO && ah < prod_q[39:0]) begin
        flags_q[axd_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    axd_q  <= cmd_i.axis;
    if (cmd_i.load) begin
      b_q[0]   <= field_x_i;
      b_q[1]   <= field_y_i;
      b_q[2]   <= field_z_i;
      h_q[0]   <= wheel_mom_x_i;
      h_q[1]   <= wheel_mom_y_i;
      h_q[2]   <= wheel_mom_z_i;
      lim_q[0] <= mom_limit_x_i;
      lim_q[1] <= mom_limit_y_i;
      lim_q[2] <= mom_limit_z_i;
    end
    case (opd_q)
      wmu_pkg::OP_SQ:  m_q <= ((axd_q == 2'd0) ? 36'd0 : m_q) + prod_q[35:0];
      wmu_pkg::OP_THR: thr2_q <= prod_q[35:0];
      wmu_pkg::OP_CP:  c_q <= prod_q[42:0];
      wmu_pkg::OP_CN:  c_q <= c_q - prod_q[42:0];
      wmu_pkg::OP_GLO: acc_q <= {20'b0, prod_q[53:0]};
      wmu_pkg::OP_GHI: acc_q <= acc_q + {prod_q[52:0], 21'b0};
      default: ;
    endcase
    if (cmd_i.decide) begin
      usable_q <= status_o.usable;
    end
    if (cmd_i.div_init) begin
      rem_q <= {10'b0, num[57:32]};
      qs_q  <= num[31:0];
      ovf_q <= {10'b0, num[57:32]} >= m_q;
      neg_q <= c_q[42];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[35:0] : trial[35:0];
      qs_q  <= {qs_q[30:0], ge};
    end
    if (cmd_i.store) begin
      case (cmd_i.axis)
        2'd1:    dip_q[1] <= sat_val;
        2'd2:    dip_q[2] <= sat_val;
        default: dip_q[0] <= sat_val;
      endcase
    end
    if (cmd_i.publish) begin
      dipole_x_o     <= usable_q ? dip_q[0] : '0;
      dipole_y_o     <= usable_q ? dip_q[1] : '0;
      dipole_z_o     <= usable_q ? dip_q[2] : '0;
      unload_mask_o  <= flags_q;
      field_usable_o <= usable_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/wmu_ctrl.sv */
// wmu_ctrl: sequencer issuing multiplier, divider and result commands
// uses wmu_pkg; drives wmu_dp through cmd_t and reads status_t
`default_nettype none

module wmu_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire wmu_pkg::status_t status_i,
  output wmu_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_DECIDE,
    ST_FLAG,
    ST_CROSS,
    ST_DIVI,
    ST_DIV,
    ST_STORE,
    ST_PUB
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic       ph_q;
  logic [1:0] axis_q;
  logic       out_valid_q;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = wmu_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_MAG: begin
        cmd_o.axis = cnt_q[1:0];
        if (!ph_q) begin
          cmd_o.op = (cnt_q == 5'd3) ? wmu_pkg::OP_THR : wmu_pkg::OP_SQ;
        end
      end
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_FLAG: begin
        cmd_o.axis = cnt_q[2:1];
        if (!ph_q) begin
          cmd_o.op = cnt_q[0] ? wmu_pkg::OP_LO : wmu_pkg::OP_HI;
        end
      end
      ST_CROSS: begin
        if (!ph_q) begin
          case (cnt_q[1:0])
            2'd0:    cmd_o.op = wmu_pkg::OP_CP;
            2'd1:    cmd_o.op = wmu_pkg::OP_CN;
            2'd2:    cmd_o.op = wmu_pkg::OP_GLO;
            default: cmd_o.op = wmu_pkg::OP_GHI;
          endcase
        end
      end
      ST_DIVI:   cmd_o.div_init = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_STORE:  cmd_o.store = 1'b1;
      ST_PUB:    cmd_o.publish = !out_valid_q || out_ready_i;
      default:   cmd_o.op = wmu_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ph_q        <= 1'b0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MAG;
            cnt_q   <= '0;
            ph_q    <= 1'b0;
          end
        end
        ST_MAG: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (cnt_q == 5'd3) begin
              state_q <= ST_DECIDE;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end
        ST_DECIDE: begin
          cnt_q   <= '0;
          axis_q  <= '0;
          state_q <= status_i.usable ? ST_FLAG : ST_PUB;
        end
        ST_FLAG: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (cnt_q == 5'd5) begin
              state_q <= ST_CROSS;
              cnt_q   <= '0;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end
        ST_CROSS: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (cnt_q == 5'd3) begin
              state_q <= ST_DIVI;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end
        ST_DIVI: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q == 5'(wmu_pkg::DivSteps - 1)) begin
            state_q <= ST_STORE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_STORE: begin
          cnt_q <= '0;
          if (axis_q == 2'd2) begin
            state_q <= ST_PUB;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_CROSS;
          end
        end
        ST_PUB: begin
          if (cmd_o.publish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.decide, cmd_o.div_init, cmd_o.div_step,
              cmd_o.store, cmd_o.publish}))
    else $error("more than one datapath action in a cycle");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MAG && cnt_q == 5'd0)
    else $error("accepted transaction did not start magnitude pass");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_init |=> ##31 cmd_o.div_step ##1 cmd_o.store)
    else $error("divider did not run its full length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.publish)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* rtl/wheel_momentum_unloading_unit.sv */
// wheel_momentum_unloading_unit: magnetic wheel momentum unloading, top level
// instantiates wmu_ctrl and wmu_dp; uses wmu_pkg
//
// one input transaction carries field, wheel momenta and momentum limits;
// one output transaction returns the three saturated dipole commands, the
// unload mask after the hysteresis update and the field usable flag
// config writes (index, data) are always ready and must be issued while idle
// a weak field skips the flag, cross product and divider passes; each
// shared multiplier operation has an issue and a result phase, and the
// divider runs 32 steps per axis; one transaction is in work at a time
// and the sequencer returns to its idle state between them
// the result sits in an output register; a new input is taken while it
// waits, but that transaction finishes only once the receiver takes the old
// result, stalling the sequencer in its final state
// reset clears the unload flags, loads the default config and empties the
// output register
`default_nettype none

module wheel_momentum_unloading_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [17:0]          field_x_i,
  input  wire logic signed [17:0]          field_y_i,
  input  wire logic signed [17:0]          field_z_i,
  input  wire logic signed [23:0]          wheel_mom_x_i,
  input  wire logic signed [23:0]          wheel_mom_y_i,
  input  wire logic signed [23:0]          wheel_mom_z_i,
  input  wire logic [22:0]                 mom_limit_x_i,
  input  wire logic [22:0]                 mom_limit_y_i,
  input  wire logic [22:0]                 mom_limit_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [31:0]               dipole_x_o,
  output logic signed [31:0]               dipole_y_o,
  output logic signed [31:0]               dipole_z_o,
  output logic [2:0]                       unload_mask_o,
  output logic                             field_usable_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [wmu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i
);

  wmu_pkg::cmd_t    cmd;
  wmu_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  wmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wmu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .field_x_i      (field_x_i),
    .field_y_i      (field_y_i),
    .field_z_i      (field_z_i),
    .wheel_mom_x_i  (wheel_mom_x_i),
    .wheel_mom_y_i  (wheel_mom_y_i),
    .wheel_mom_z_i  (wheel_mom_z_i),
    .mom_limit_x_i  (mom_limit_x_i),
    .mom_limit_y_i  (mom_limit_y_i),
    .mom_limit_z_i  (mom_limit_z_i),
    .dipole_x_o     (dipole_x_o),
    .dipole_y_o     (dipole_y_o),
    .dipole_z_o     (dipole_z_o),
    .unload_mask_o  (unload_mask_o),
    .field_usable_o (field_usable_o)
  );

endmodule

`default_nettype wire
